// File: hdl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Widths, constants and the command and status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the number field on the input channel.
    localparam int INPUT_WIDTH  = 16;
    // Width of the number actually tested; higher input bits are ignored.
    localparam int NUMBER_WIDTH = 16;
    // A trial divisor never exceeds 2**(NUMBER_WIDTH/2) + 1.
    localparam int DIV_W        = NUMBER_WIDTH / 2 + 1;
    // The running square of the divisor.
    localparam int SQ_W         = 2 * DIV_W;
    // Partial remainder after the shift, one bit wider than the divisor.
    localparam int REM_W        = DIV_W + 1;
    // Index of the dividend bit being brought down.
    localparam int BIT_W        = $clog2(NUMBER_WIDTH);

    // First trial divisor and its square.
    localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(2);
    localparam logic [SQ_W-1:0]  FIRST_SQUARE  = SQ_W'(4);

    typedef struct packed {
        logic load;          // capture a new number, restart the divisor
        logic div_start;     // clear the remainder, start at the top bit
        logic div_step;      // one restoring division step
        logic next_divisor;  // advance divisor and its square
    } tdpt_cmd_t;

    typedef struct packed {
        logic below_two;     // number is zero or one
        logic bound_passed;  // divisor squared exceeds the number
        logic div_last;      // the current step is the final one
        logic rem_zero;      // remainder of the finished division is zero
    } tdpt_status_t;

endpackage

// File: hdl/tdpt_if.sv
// ----------------------------------------------------------------------------
// Trial division prime test channels
// Valid/ready channel for the tested number and for the verdict.
// ----------------------------------------------------------------------------
interface tdpt_in_if
    import tdpt_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [INPUT_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface tdpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// File: hdl/trial_division_prime_test_core.sv
// ----------------------------------------------------------------------------
// Trial division prime test core
// The time to a valid verdict depends on the number: numbers below 4 are
// settled by the first bound check, others take a bound check, a full
// division and a remainder test per trial divisor until a zero remainder
// or a passed bound. One number is handled at a time; the next is taken
// once the verdict sits in the output register.
// Reset clears the controller, the datapath and the output valid flag
// asynchronously.
// ----------------------------------------------------------------------------
//
// The number arrives on the item channel and is captured in the datapath.
// The controller then walks trial divisors upward from two. Before each
// divisor the running square is compared with the number; once the square
// exceeds it, no factor remains and the number is prime. Otherwise the
// remainder is formed one dividend bit per cycle by a restoring divider,
// and a zero remainder ends the search with a not-prime verdict. Zero and
// one are reported as not prime straight away.
//
// The verdict goes into an output register, so a finished result may wait
// for its transfer while the core already takes the next number.
module trial_division_prime_test_core
    import tdpt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    tdpt_in_if.sink    item,
    tdpt_out_if.source result
);

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    // Sequencing and the output register.
    tdpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .is_prime  (result.is_prime),
        .cmd       (cmd),
        .status    (status)
    );

    // Number, divisor, square and remainder arithmetic.
    tdpt_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (item.number),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// File: hdl/tdpt_dp.sv
// ----------------------------------------------------------------------------
// Trial division prime test datapath
// Holds the number, the trial divisor with its running square, and a
// one-bit-per-cycle restoring remainder unit.
// ----------------------------------------------------------------------------
module tdpt_dp
    import tdpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [INPUT_WIDTH-1:0] number,
    input  tdpt_cmd_t              cmd,
    output tdpt_status_t           status
);

    logic [NUMBER_WIDTH-1:0] value_reg;
    logic [DIV_W-1:0]        divisor_reg;
    logic [SQ_W-1:0]         square_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [BIT_W-1:0]        bit_reg;

    logic [REM_W-1:0]        rem_shift;
    logic [REM_W-1:0]        rem_next;
    logic [SQ_W-1:0]         square_next;

    // Bring the next dividend bit down and subtract when the divisor fits.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], value_reg[bit_reg]};
        if (rem_shift >= REM_W'(divisor_reg))
        begin
            rem_next = rem_shift - REM_W'(divisor_reg);
        end
        else
        begin
            rem_next = rem_shift;
        end
    end

    // (d+1)^2 = d^2 + 2d + 1
    assign square_next = square_reg + SQ_W'({divisor_reg, 1'b1});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg   <= '0;
            divisor_reg <= FIRST_DIVISOR;
            square_reg  <= FIRST_SQUARE;
            rem_reg     <= '0;
            bit_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                value_reg   <= number[NUMBER_WIDTH-1:0];
                divisor_reg <= FIRST_DIVISOR;
                square_reg  <= FIRST_SQUARE;
            end
            else if (cmd.next_divisor)
            begin
                divisor_reg <= divisor_reg + DIV_W'(1);
                square_reg  <= square_next;
            end

            if (cmd.div_start)
            begin
                rem_reg <= '0;
                bit_reg <= BIT_W'(NUMBER_WIDTH - 1);
            end
            else if (cmd.div_step)
            begin
                rem_reg <= rem_next;
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
    end

    assign status.below_two    = (value_reg < NUMBER_WIDTH'(2));
    assign status.bound_passed = (square_reg > SQ_W'(value_reg));
    assign status.div_last     = (bit_reg == '0);
    assign status.rem_zero     = (rem_reg == '0);

endmodule

// File: hdl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// Trial division prime test controller
// Sequences load, bound check, division and divisor advance, and holds
// the verdict in an output register until its transfer completes.
// ----------------------------------------------------------------------------
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         is_prime,
    output tdpt_cmd_t    cmd,
    input  tdpt_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_TEST,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   verdict_reg;
    logic   out_valid_reg;
    logic   is_prime_reg;

    always_comb
    begin
        cmd.load         = (state_reg == ST_IDLE) && in_valid;
        cmd.div_start    = (state_reg == ST_CHECK) && !status.below_two
                           && !status.bound_passed;
        cmd.div_step     = (state_reg == ST_DIVIDE);
        cmd.next_divisor = (state_reg == ST_TEST) && !status.rem_zero;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            is_prime_reg  <= 1'b0;
        end
        else
        begin
            // In the finishing state the new verdict takes the place of the
            // one being transferred, so the flag is only cleared elsewhere.
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (status.below_two)
                    begin
                        verdict_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                    else if (status.bound_passed)
                    begin
                        verdict_reg <= 1'b1;
                        state_reg   <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (status.div_last)
                    begin
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST:
                begin
                    if (status.rem_zero)
                    begin
                        verdict_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        is_prime_reg  <= verdict_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
